// File: hdl/dplt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dplt_pkg;

   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// File: hdl/dplt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dplt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/demand_paging_lru_translator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Demand-paging address translator with true LRU frame replacement. Each request word is a
// logical address (page number above the offset); the response word carries the physical
// address (frame above the same offset), a page-fault flag, the evicted page if any, and a
// saturating fault count. Residency is found by searching the per-frame table (owner page,
// in-use flag, recency rank) held in one small RAM, so there is no per-page table. Frame 0 is
// reserved. Each request makes one read pass over frames 1..FRAME_COUNT-1 to find a hit, the
// lowest free frame or the oldest frame, then one read-modify-write pass to update ranks over
// the single RAM port pair. The block takes one request at a time; a finished response waits
// in an output register while the next request is taken. After reset a clearing pass over
// every frame runs before the first request is accepted.
module demand_paging_lru_translator_unit #(
   parameter int PAGE_BITS   = 5,
   parameter int OFFSET_BITS = 7,
   parameter int FRAME_COUNT = 8,
   localparam int FRAME_BITS = $clog2(FRAME_COUNT),
   localparam int REQ_BITS   = PAGE_BITS + OFFSET_BITS,
   localparam int REQ_WIDTH  = ((REQ_BITS + 7) / 8) * 8,
   localparam int PA_BITS    = FRAME_BITS + OFFSET_BITS,
   localparam int RSP_BITS   = PA_BITS + 2 + PAGE_BITS + 32,
   localparam int RSP_WIDTH  = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // logical_address
   input  wire [REQ_WIDTH-1:0]   req_tdata,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // physical_address, page_fault, evicted_valid, evicted_page, fault_total
   output logic [RSP_WIDTH-1:0]  rsp_tdata
);

   import dplt_pkg::*;

   localparam int ENTRY_BITS = PAGE_BITS + 1 + FRAME_BITS;
   localparam logic [FRAME_BITS-1:0] FRAME_FIRST = FRAME_BITS'(1);
   localparam logic [FRAME_BITS-1:0] FRAME_LAST  = FRAME_BITS'(FRAME_COUNT - 1);

   typedef struct packed {
      logic [PAGE_BITS-1:0]  owner;
      logic                  used;
      logic [FRAME_BITS-1:0] age;
   } entry_type;

   state_type state_ff, state_in;

   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [FRAME_BITS-1:0]  addr_ff, addr_in;
   logic                   issue_ff, issue_in;
   logic                   tap_valid_ff, tap_valid_in;
   logic [FRAME_BITS-1:0]  tap_idx_ff, tap_idx_in;

   logic                   hit_ff, hit_in;
   logic [FRAME_BITS-1:0]  sel_ff, sel_in;
   logic [FRAME_BITS-1:0]  rank_ff, rank_in;
   logic                   free_found_ff, free_found_in;
   logic [FRAME_BITS-1:0]  free_ff, free_in;
   logic                   best_valid_ff, best_valid_in;
   logic [FRAME_BITS-1:0]  best_ff, best_in;
   logic [FRAME_BITS-1:0]  best_age_ff, best_age_in;
   logic [PAGE_BITS-1:0]   best_owner_ff, best_owner_in;

   logic [FRAME_BITS-1:0]  tgt_ff, tgt_in;
   logic [FRAME_BITS-1:0]  lim_ff, lim_in;
   logic                   fill_all_ff, fill_all_in;
   logic                   fault_ff, fault_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [PAGE_BITS-1:0]   ev_page_ff, ev_page_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]   rsp_data_ff, rsp_data_in;

   logic                   wr_en;
   logic [FRAME_BITS-1:0]  wr_addr;
   entry_type              wr_entry;
   logic [ENTRY_BITS-1:0]  rd_data;
   entry_type              rd_entry;

   assign rd_entry = entry_type'(rd_data);

   dplt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (FRAME_COUNT)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_BITS'(wr_entry)),
      .rd_en   (issue_ff),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      offset_in     = offset_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      tap_valid_in  = issue_ff;
      tap_idx_in    = addr_ff;
      hit_in        = hit_ff;
      sel_in        = sel_ff;
      rank_in       = rank_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      best_valid_in = best_valid_ff;
      best_in       = best_ff;
      best_age_in   = best_age_ff;
      best_owner_in = best_owner_ff;
      tgt_in        = tgt_ff;
      lim_in        = lim_ff;
      fill_all_in   = fill_all_ff;
      fault_in      = fault_ff;
      ev_valid_in   = ev_valid_ff;
      ev_page_in    = ev_page_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = tap_idx_ff;
      wr_entry      = rd_entry;

      // advance the read pointer over frames 1..last
      if (issue_ff) begin
         if (addr_ff == FRAME_LAST) begin
            issue_in = 1'b0;
         end else begin
            addr_in = addr_ff + FRAME_FIRST;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en          = 1'b1;
            wr_addr        = addr_ff;
            wr_entry.owner = '0;
            wr_entry.used  = 1'b0;
            wr_entry.age   = '0;
            if (addr_ff == FRAME_LAST) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + FRAME_FIRST;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               page_in       = req_tdata[REQ_BITS-1:OFFSET_BITS];
               offset_in     = req_tdata[OFFSET_BITS-1:0];
               addr_in       = FRAME_FIRST;
               issue_in      = 1'b1;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               best_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tap_valid_ff) begin
               if (rd_entry.used && rd_entry.owner == page_ff) begin
                  hit_in  = 1'b1;
                  sel_in  = tap_idx_ff;
                  rank_in = rd_entry.age;
               end
               if (!rd_entry.used && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = tap_idx_ff;
               end
               if (rd_entry.used && (!best_valid_ff || rd_entry.age > best_age_ff)) begin
                  best_valid_in = 1'b1;
                  best_in       = tap_idx_ff;
                  best_age_in   = rd_entry.age;
                  best_owner_in = rd_entry.owner;
               end
               if (tap_idx_ff == FRAME_LAST) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            fill_all_in = 1'b0;
            fault_in    = !hit_ff;
            ev_valid_in = 1'b0;
            ev_page_in  = '0;
            if (!hit_ff && count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
            priority if (hit_ff) begin
               tgt_in = sel_ff;
               lim_in = rank_ff;
            end else if (free_found_ff) begin
               tgt_in      = free_ff;
               lim_in      = '0;
               fill_all_in = 1'b1;
            end else begin
               tgt_in      = best_ff;
               lim_in      = best_age_ff;
               ev_valid_in = 1'b1;
               ev_page_in  = best_owner_ff;
            end
            addr_in  = FRAME_FIRST;
            issue_in = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (tap_valid_ff) begin
               wr_en = 1'b1;
               if (tap_idx_ff == tgt_ff) begin
                  wr_entry.owner = page_ff;
                  wr_entry.used  = 1'b1;
                  wr_entry.age   = '0;
               end else if (rd_entry.used && (fill_all_ff || rd_entry.age < lim_ff)) begin
                  wr_entry.age = rd_entry.age + FRAME_BITS'(1);
               end
               if (tap_idx_ff == FRAME_LAST) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_WIDTH'({count_ff, ev_page_ff, ev_valid_ff, fault_ff,
                                          tgt_ff, offset_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         tap_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issue_ff     <= issue_in;
         tap_valid_ff <= tap_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      offset_ff     <= offset_in;
      tap_idx_ff    <= tap_idx_in;
      hit_ff        <= hit_in;
      sel_ff        <= sel_in;
      rank_ff       <= rank_in;
      free_found_ff <= free_found_in;
      free_ff       <= free_in;
      best_valid_ff <= best_valid_in;
      best_ff       <= best_in;
      best_age_ff   <= best_age_in;
      best_owner_ff <= best_owner_in;
      tgt_ff        <= tgt_in;
      lim_ff        <= lim_in;
      fill_all_ff   <= fill_all_in;
      fault_ff      <= fault_in;
      ev_valid_ff   <= ev_valid_in;
      ev_page_ff    <= ev_page_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAMES      = 8;
   localparam int PAGES       = 32;
   localparam int RSP_BITS    = 49;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 60;

   typedef struct packed {
      logic [31:0] fault_total;
      logic [4:0]  evicted_page;
      logic        evicted_valid;
      logic        page_fault;
      logic [9:0]  physical_address;
   } xlat_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [55:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_left = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   logic        page_resident [PAGES];
   logic [2:0]  page_slot     [PAGES];
   logic [4:0]  slot_page     [FRAMES];
   logic        slot_free     [FRAMES];
   logic [2:0]  slot_rank     [FRAMES];
   logic [31:0] faults_so_far;

   xlat_result_type pending_translations [$];

   demand_paging_lru_translator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic void clear_page_map();
      for (int p = 0; p < PAGES; p++) begin
         page_resident[p] = 1'b0;
         page_slot[p] = '0;
      end
      for (int g = 0; g < FRAMES; g++) begin
         slot_page[g] = '0;
         slot_free[g] = (g != 0);
         slot_rank[g] = '0;
      end
      faults_so_far = '0;
   endfunction

   // make slot the most recent; every used slot younger than older_than ages by one
   function automatic void age_frames(int slot, int older_than);
      for (int g = 1; g < FRAMES; g++)
         if (g != slot && !slot_free[g] && int'(slot_rank[g]) < older_than)
            slot_rank[g] = slot_rank[g] + 3'd1;
      slot_rank[slot] = '0;
   endfunction

   function automatic void translate_address(logic [11:0] la);
      xlat_result_type r;
      logic [4:0]      page;
      int              slot;
      page = la[11:7];
      r = '0;
      if (page_resident[page]) begin
         slot = page_slot[page];
         age_frames(slot, slot_rank[slot]);
      end else begin
         r.page_fault = 1'b1;
         if (faults_so_far != '1)
            faults_so_far = faults_so_far + 32'd1;
         slot = 0;
         for (int g = FRAMES - 1; g >= 1; g--)
            if (slot_free[g])
               slot = g;
         if (slot != 0) begin
            age_frames(slot, 255);
            slot_free[slot] = 1'b0;
         end else begin
            slot = 1;
            for (int g = 2; g < FRAMES; g++)
               if (slot_rank[g] > slot_rank[slot])
                  slot = g;
            r.evicted_valid = 1'b1;
            r.evicted_page = slot_page[slot];
            page_resident[slot_page[slot]] = 1'b0;
            age_frames(slot, slot_rank[slot]);
         end
         page_resident[page] = 1'b1;
         page_slot[page] = 3'(slot);
         slot_page[slot] = page;
      end
      r.physical_address = {3'(slot), la[6:0]};
      r.fault_total = faults_so_far;
      pending_translations.push_back(r);
   endfunction

   // call at a falling edge; returns at the falling edge after the word is taken
   task automatic send_address(input logic [11:0] la);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, la};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      translate_address(la);
      @(negedge clock);
   endtask

   task automatic release_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_translations.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_field_extremes();
      send_address(12'h000);
      send_address(12'hFFF);
      send_address(12'h07F);
      send_address(12'hF80);
      send_address(12'h555);
      send_address(12'hAAA);
   endtask

   task automatic test_lru_replacement();
      for (int p = 1; p <= 4; p++)
         send_address({5'(p), 7'($urandom_range(127))});
      send_address({5'd0, 7'h11});
      send_address({5'd6, 7'h22});
      send_address({5'd7, 7'h33});
      send_address({5'd31, 7'h44});
      send_address({5'd8, 7'h55});
      send_address({5'd9, 7'h66});
      send_address({5'd10, 7'h77});
      send_address({5'd1, 7'h01});
      send_address({5'd10, 7'h02});
      send_address({5'd2, 7'h03});
      send_address({5'd11, 7'h04});
      send_address({5'd6, 7'h05});
   endtask

   task automatic test_random_access(input int send_pct, input int recv_pct, input int count);
      logic [4:0] hot_pages [10];
      int         hot_size;
      logic [4:0] last_page;
      logic [4:0] page;
      int         pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      hot_size = 8;
      last_page = '0;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            hot_size = $urandom_range(10, 4);
            foreach (hot_pages[k])
               hot_pages[k] = 5'($urandom_range(31));
         end
         pick = $urandom_range(99);
         if (pick < 70)
            page = hot_pages[$urandom_range(hot_size - 1)];
         else if (pick < 85)
            page = last_page;
         else
            page = 5'($urandom_range(31));
         last_page = page;
         send_address({page, 7'($urandom_range(127))});
      end
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      release_request();
      wait_drained();
      rsp_hold_left = 400;
      @(negedge clock);
      for (int n = 0; n < 12; n++)
         send_address(12'($urandom_range(4095)));
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      xlat_result_type got;
      xlat_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_BITS-1:0];
         if (pending_translations.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_translations.pop_front();
            if (got.physical_address !== want.physical_address) begin
               $error("physical_address: expected %h, got %h",
                      want.physical_address, got.physical_address);
               mismatch_count++;
            end
            if (got.page_fault !== want.page_fault) begin
               $error("page_fault: expected %b, got %b", want.page_fault, got.page_fault);
               mismatch_count++;
            end
            if (got.evicted_valid !== want.evicted_valid) begin
               $error("evicted_valid: expected %b, got %b",
                      want.evicted_valid, got.evicted_valid);
               mismatch_count++;
            end
            if (got.evicted_page !== want.evicted_page) begin
               $error("evicted_page: expected %0d, got %0d",
                      want.evicted_page, got.evicted_page);
               mismatch_count++;
            end
            if (got.fault_total !== want.fault_total) begin
               $error("fault_total: expected %0d, got %0d", want.fault_total, got.fault_total);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      clear_page_map();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 36;
      recv_idle_pct = 75;
      test_field_extremes();
      test_lru_replacement();
      test_random_access(36, 75, 470);
      test_random_access(75, 36, 470);
      test_random_access(0, 0, 470);
      test_output_backpressure();
      release_request();
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
